FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication property
`define AP_ASSERT(lbl, c, r, prop, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);
// next-cycle implication
`define AP_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);
`else
`define AP_ASSERT(lbl, c, r, prop, msg)
`define AP_ASSERT_NEXT(lbl, c, r, ante, cons, msg)
`endif

`endif

FILE: rtl/aprs_pfmt_pkg.sv
// ----------------------------------------------------------------------------
// aprs_pfmt_pkg
// Shared types and constants of the APRS position formatter.
// ----------------------------------------------------------------------------
package aprs_pfmt_pkg;

    typedef struct packed {
        logic        err;
        logic        lat_neg;
        logic [27:0] lat_mag;
        logic        lon_neg;
        logic [27:0] lon_mag;
    } pos_item_t;

    typedef enum logic [2:0] {
        STEP_DEG,
        STEP_REM,
        STEP_SCALE,
        STEP_MIN,
        STEP_REM2,
        STEP_HUN,
        STEP_DONE
    } step_t;

    typedef enum logic [1:0] {
        CFG_SYMBOL_TABLE = 2'd0,
        CFG_SYMBOL_CODE  = 2'd1,
        CFG_AMBIGUITY    = 2'd2
    } cfg_index_t;

    localparam logic signed [31:0] LAT_LIMIT = 32'sd90000000;
    localparam logic signed [31:0] LON_LIMIT = 32'sd180000000;

    // ceil(2^48 / 1e6) and ceil(2^34 / 1e4)
    localparam logic [28:0] RECIP_MICRO = 29'd281474977;
    localparam logic [28:0] RECIP_1E4   = 29'd1717987;
    localparam logic [28:0] MICRO       = 29'd1000000;
    localparam logic [28:0] SIXTY       = 29'd60;

    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [7:0] SYMBOL_TABLE_RESET = 8'd47;
    localparam logic [7:0] SYMBOL_CODE_RESET  = 8'd42;

    localparam logic [4:0] IDX_TABLE = 5'd8;
    localparam logic [4:0] IDX_LON   = 5'd9;
    localparam logic [4:0] IDX_LAST  = 5'd18;

endpackage

FILE: rtl/aprs_pfmt_ifs.sv
// ----------------------------------------------------------------------------
// aprs_pfmt_ifs
// Valid/ready channels: position input, report output, register writes.
// ----------------------------------------------------------------------------
interface aprs_pfmt_pos_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] latitude_microdeg;
    logic signed [31:0] longitude_microdeg;

    modport source (output valid, latitude_microdeg, longitude_microdeg, input ready);
    modport sink   (input valid, latitude_microdeg, longitude_microdeg, output ready);
endinterface

interface aprs_pfmt_rpt_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic       range_error;

    modport source (output valid, character, last, range_error, input ready);
    modport sink   (input valid, character, last, range_error, output ready);
endinterface

interface aprs_pfmt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/aprs_pfmt_front.sv
// ----------------------------------------------------------------------------
// aprs_pfmt_front
// Accepts positions, range checks them, splits sign and magnitude.
// ----------------------------------------------------------------------------
module aprs_pfmt_front (
    aprs_pfmt_pos_if.sink          pos,
    output logic                   push_valid,
    output aprs_pfmt_pkg::pos_item_t push_item,
    input  logic                   push_ready
);
    import aprs_pfmt_pkg::*;

    logic        lat_bad;
    logic        lon_bad;
    logic [31:0] lat_abs;
    logic [31:0] lon_abs;

    assign lat_bad = (pos.latitude_microdeg > LAT_LIMIT) ||
                     (pos.latitude_microdeg < -LAT_LIMIT);
    assign lon_bad = (pos.longitude_microdeg > LON_LIMIT) ||
                     (pos.longitude_microdeg < -LON_LIMIT);

    assign lat_abs = pos.latitude_microdeg[31] ? 32'(-pos.latitude_microdeg)
                                               : 32'(pos.latitude_microdeg);
    assign lon_abs = pos.longitude_microdeg[31] ? 32'(-pos.longitude_microdeg)
                                                : 32'(pos.longitude_microdeg);

    always_comb
    begin
        push_item.err     = lat_bad || lon_bad;
        push_item.lat_neg = pos.latitude_microdeg[31];
        push_item.lat_mag = lat_abs[27:0];
        push_item.lon_neg = pos.longitude_microdeg[31];
        push_item.lon_mag = lon_abs[27:0];
    end

    assign push_valid = pos.valid;
    assign pos.ready  = push_ready;

endmodule

FILE: rtl/aprs_pfmt_queue.sv
// ----------------------------------------------------------------------------
// aprs_pfmt_queue
// Short FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aprs_pfmt_queue #(
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    input  aprs_pfmt_pkg::pos_item_t push_item,
    output logic                     push_ready,
    output logic                     pop_valid,
    output aprs_pfmt_pkg::pos_item_t pop_item,
    input  logic                     pop_ready
);
    import aprs_pfmt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pos_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `AP_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue overfilled")
    `AP_ASSERT_NEXT(a_count_up, clk, rst_n, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1, "count did not rise")
    `AP_ASSERT_NEXT(a_count_dn, clk, rst_n, pop_fire && !push_fire, count_reg == $past(count_reg) - 1'b1, "count did not fall")

endmodule

FILE: rtl/aprs_pfmt_lane.sv
// ----------------------------------------------------------------------------
// aprs_pfmt_lane
// Splits one coordinate magnitude into degrees, minutes and hundredths
// with a single reciprocal multiplier stepped by the back end.
// ----------------------------------------------------------------------------
module aprs_pfmt_lane (
    input  logic                 clk,
    input  logic                 load,
    input  logic [27:0]          mag,
    input  aprs_pfmt_pkg::step_t step,
    output logic [7:0]           deg,
    output logic [5:0]           mnt,
    output logic [6:0]           hun
);
    import aprs_pfmt_pkg::*;

    logic [27:0] w_reg, w_next;
    logic [7:0]  deg_reg, deg_next;
    logic [5:0]  mnt_reg, mnt_next;
    logic [6:0]  hun_reg, hun_next;
    logic [27:0] mul_a;
    logic [28:0] mul_b;
    logic [56:0] prod;

    always_comb
    begin
        case (step)
            STEP_DEG:   begin mul_a = w_reg;                mul_b = RECIP_MICRO; end
            STEP_REM:   begin mul_a = {20'd0, deg_reg};     mul_b = MICRO;       end
            STEP_SCALE: begin mul_a = w_reg;                mul_b = SIXTY;       end
            STEP_MIN:   begin mul_a = w_reg;                mul_b = RECIP_MICRO; end
            STEP_REM2:  begin mul_a = {22'd0, mnt_reg};     mul_b = MICRO;       end
            STEP_HUN:   begin mul_a = w_reg;                mul_b = RECIP_1E4;   end
            default:    begin mul_a = '0;                   mul_b = '0;          end
        endcase
    end

    assign prod = 57'(mul_a) * 57'(mul_b);

    always_comb
    begin
        w_next   = w_reg;
        deg_next = deg_reg;
        mnt_next = mnt_reg;
        hun_next = hun_reg;
        if (load)
        begin
            w_next = mag;
        end
        else
        begin
            case (step)
                STEP_DEG:   deg_next = prod[55:48];
                STEP_REM:   w_next   = w_reg - prod[27:0];
                STEP_SCALE: w_next   = prod[27:0];
                STEP_MIN:   mnt_next = prod[53:48];
                STEP_REM2:  w_next   = w_reg - prod[27:0];
                STEP_HUN:   hun_next = prod[40:34];
                default:    w_next   = w_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        deg_reg <= deg_next;
        mnt_reg <= mnt_next;
        hun_reg <= hun_next;
    end

    assign deg = deg_reg;
    assign mnt = mnt_reg;
    assign hun = hun_reg;

endmodule

FILE: rtl/aprs_pfmt_back.sv
// ----------------------------------------------------------------------------
// aprs_pfmt_back
// Converts queued positions in two lanes and serializes the report bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aprs_pfmt_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pop_valid,
    input  aprs_pfmt_pkg::pos_item_t pop_item,
    output logic                     pop_ready,
    input  logic [6:0]               symbol_table,
    input  logic [6:0]               symbol_code,
    input  logic [2:0]               ambiguity,
    aprs_pfmt_rpt_if.source          rpt
);
    import aprs_pfmt_pkg::*;

    function automatic logic [7:0] div10(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return {3'd0, p[15:11]};
    endfunction

    function automatic logic [7:0] mul10(input logic [7:0] x);
        return 8'({x[4:0], 3'd0}) + 8'({x[6:0], 1'b0});
    endfunction

    function automatic logic [7:0] digit(input logic [7:0] d);
        return CH_ZERO + {4'd0, d[3:0]};
    endfunction

    // sel: hundreds, tens, units of degrees, minute tens/units, dot,
    // hundredth tens/units, hemisphere
    function automatic logic [7:0] coord_char(
        input logic [3:0] sel,
        input logic [7:0] deg,
        input logic [5:0] mnt,
        input logic [6:0] hun,
        input logic       neg,
        input logic [7:0] pos_ch,
        input logic [7:0] neg_ch,
        input logic [2:0] amb
    );
        logic [7:0] dq;
        logic [7:0] d2;
        logic [7:0] mq;
        logic [7:0] hq;
        logic [7:0] ch;
        dq = div10(deg);
        d2 = div10(dq);
        mq = div10({2'd0, mnt});
        hq = div10({1'b0, hun});
        case (sel)
            4'd0:    ch = digit(d2);
            4'd1:    ch = digit(dq - mul10(d2));
            4'd2:    ch = digit(deg - mul10(dq));
            4'd3:    ch = (amb > 3'd3) ? CH_SPACE : digit(mq);
            4'd4:    ch = (amb > 3'd2) ? CH_SPACE : digit({2'd0, mnt} - mul10(mq));
            4'd5:    ch = CH_DOT;
            4'd6:    ch = (amb > 3'd1) ? CH_SPACE : digit(hq);
            4'd7:    ch = (amb > 3'd0) ? CH_SPACE : digit({1'b0, hun} - mul10(hq));
            4'd8:    ch = neg ? neg_ch : pos_ch;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

    logic        conv_valid_reg, conv_valid_next;
    logic        conv_err_reg, conv_err_next;
    logic        conv_lat_neg_reg, conv_lat_neg_next;
    logic        conv_lon_neg_reg, conv_lon_neg_next;
    step_t       step_reg, step_next;
    step_t       lane_step;

    logic [7:0]  lat_deg, lon_deg;
    logic [5:0]  lat_mnt, lon_mnt;
    logic [6:0]  lat_hun, lon_hun;

    logic        emit_valid_reg, emit_valid_next;
    logic [4:0]  emit_idx_reg, emit_idx_next;
    logic        emit_err_reg, emit_err_next;
    logic        emit_lat_neg_reg, emit_lat_neg_next;
    logic        emit_lon_neg_reg, emit_lon_neg_next;
    logic [7:0]  emit_lat_deg_reg, emit_lat_deg_next;
    logic [5:0]  emit_lat_mnt_reg, emit_lat_mnt_next;
    logic [6:0]  emit_lat_hun_reg, emit_lat_hun_next;
    logic [7:0]  emit_lon_deg_reg, emit_lon_deg_next;
    logic [5:0]  emit_lon_mnt_reg, emit_lon_mnt_next;
    logic [6:0]  emit_lon_hun_reg, emit_lon_hun_next;

    logic        pop_fire;
    logic        conv_done;
    logic        out_fire;
    logic        out_last;
    logic        handoff;
    logic [3:0]  lat_sel;
    logic [3:0]  lon_sel;
    logic [7:0]  report_char;

    assign pop_ready = !conv_valid_reg;
    assign pop_fire  = pop_valid && pop_ready;
    assign conv_done = conv_valid_reg && (step_reg == STEP_DONE);
    assign out_fire  = rpt.valid && rpt.ready;
    assign out_last  = emit_err_reg || (emit_idx_reg == IDX_LAST);
    assign handoff   = conv_done && (!emit_valid_reg || (out_fire && out_last));
    assign lane_step = conv_valid_reg ? step_reg : STEP_DONE;

    aprs_pfmt_lane u_lat (
        .clk  (clk),
        .load (pop_fire),
        .mag  (pop_item.lat_mag),
        .step (lane_step),
        .deg  (lat_deg),
        .mnt  (lat_mnt),
        .hun  (lat_hun)
    );

    aprs_pfmt_lane u_lon (
        .clk  (clk),
        .load (pop_fire),
        .mag  (pop_item.lon_mag),
        .step (lane_step),
        .deg  (lon_deg),
        .mnt  (lon_mnt),
        .hun  (lon_hun)
    );

    always_comb
    begin
        conv_valid_next   = conv_valid_reg;
        conv_err_next     = conv_err_reg;
        conv_lat_neg_next = conv_lat_neg_reg;
        conv_lon_neg_next = conv_lon_neg_reg;
        step_next         = step_reg;
        if (pop_fire)
        begin
            conv_valid_next   = 1'b1;
            conv_err_next     = pop_item.err;
            conv_lat_neg_next = pop_item.lat_neg;
            conv_lon_neg_next = pop_item.lon_neg;
            step_next         = pop_item.err ? STEP_DONE : STEP_DEG;
        end
        else if (handoff)
        begin
            conv_valid_next = 1'b0;
        end
        else if (conv_valid_reg && (step_reg != STEP_DONE))
        begin
            step_next = step_t'(step_reg + 3'd1);
        end
    end

    always_comb
    begin
        emit_valid_next   = emit_valid_reg;
        emit_idx_next     = emit_idx_reg;
        emit_err_next     = emit_err_reg;
        emit_lat_neg_next = emit_lat_neg_reg;
        emit_lon_neg_next = emit_lon_neg_reg;
        emit_lat_deg_next = emit_lat_deg_reg;
        emit_lat_mnt_next = emit_lat_mnt_reg;
        emit_lat_hun_next = emit_lat_hun_reg;
        emit_lon_deg_next = emit_lon_deg_reg;
        emit_lon_mnt_next = emit_lon_mnt_reg;
        emit_lon_hun_next = emit_lon_hun_reg;
        if (handoff)
        begin
            emit_valid_next   = 1'b1;
            emit_idx_next     = '0;
            emit_err_next     = conv_err_reg;
            emit_lat_neg_next = conv_lat_neg_reg;
            emit_lon_neg_next = conv_lon_neg_reg;
            emit_lat_deg_next = lat_deg;
            emit_lat_mnt_next = lat_mnt;
            emit_lat_hun_next = lat_hun;
            emit_lon_deg_next = lon_deg;
            emit_lon_mnt_next = lon_mnt;
            emit_lon_hun_next = lon_hun;
        end
        else if (out_fire)
        begin
            if (out_last)
            begin
                emit_valid_next = 1'b0;
            end
            else
            begin
                emit_idx_next = emit_idx_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_valid_reg <= 1'b0;
            step_reg       <= STEP_DONE;
            emit_valid_reg <= 1'b0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            conv_valid_reg <= conv_valid_next;
            step_reg       <= step_next;
            emit_valid_reg <= emit_valid_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_err_reg     <= conv_err_next;
        conv_lat_neg_reg <= conv_lat_neg_next;
        conv_lon_neg_reg <= conv_lon_neg_next;
        emit_err_reg     <= emit_err_next;
        emit_lat_neg_reg <= emit_lat_neg_next;
        emit_lon_neg_reg <= emit_lon_neg_next;
        emit_lat_deg_reg <= emit_lat_deg_next;
        emit_lat_mnt_reg <= emit_lat_mnt_next;
        emit_lat_hun_reg <= emit_lat_hun_next;
        emit_lon_deg_reg <= emit_lon_deg_next;
        emit_lon_mnt_reg <= emit_lon_mnt_next;
        emit_lon_hun_reg <= emit_lon_hun_next;
    end

    // latitude skips the hundreds-of-degrees slot
    assign lat_sel = 4'(emit_idx_reg + 5'd1);
    assign lon_sel = 4'(emit_idx_reg - IDX_LON);

    always_comb
    begin
        if (emit_idx_reg < IDX_TABLE)
        begin
            report_char = coord_char(lat_sel, emit_lat_deg_reg, emit_lat_mnt_reg,
                                     emit_lat_hun_reg, emit_lat_neg_reg, CH_N, CH_S,
                                     ambiguity);
        end
        else if (emit_idx_reg == IDX_TABLE)
        begin
            report_char = {1'b0, symbol_table};
        end
        else if (emit_idx_reg < IDX_LAST)
        begin
            report_char = coord_char(lon_sel, emit_lon_deg_reg, emit_lon_mnt_reg,
                                     emit_lon_hun_reg, emit_lon_neg_reg, CH_E, CH_W,
                                     ambiguity);
        end
        else
        begin
            report_char = {1'b0, symbol_code};
        end
    end

    assign rpt.valid       = emit_valid_reg;
    assign rpt.last        = out_last;
    assign rpt.range_error = emit_err_reg;
    assign rpt.character   = emit_err_reg ? 8'd0 : report_char;

    `AP_ASSERT_NEXT(a_pop_starts, clk, rst_n, pop_fire, conv_valid_reg, "conversion not started")
    `AP_ASSERT_NEXT(a_handoff, clk, rst_n, handoff, emit_valid_reg && (emit_idx_reg == 5'd0), "report not loaded")
    `AP_ASSERT(a_idx_bound, clk, rst_n, emit_valid_reg |-> (emit_idx_reg <= IDX_LAST), "byte index past end")
    `AP_ASSERT(a_err_byte, clk, rst_n, (rpt.valid && rpt.range_error) |-> (rpt.last && (rpt.character == 8'd0)), "bad error transaction")

endmodule

FILE: rtl/aprs_position_field_formatter.sv
// ----------------------------------------------------------------------------
// aprs_position_field_formatter
// Formats a signed-microdegree position into the 19-byte APRS base report.
// ----------------------------------------------------------------------------
// A position in range produces 19 report transactions, one byte per cycle
// while the report side is ready; an out-of-range position produces one
// transaction. The byte serializer, not the conversion, limits how often a
// new position is taken: conversion to degrees, minutes and hundredths uses
// one reciprocal multiplier per coordinate and overlaps the previous report.
// An accepted position passes the queue, the conversion steps and the emit
// registers before its first byte appears. A QUEUE_DEPTH-entry queue sits
// between the input and the converter. Register writes are taken every cycle.
// ----------------------------------------------------------------------------
module aprs_position_field_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    aprs_pfmt_pos_if.sink   pos,
    aprs_pfmt_rpt_if.source rpt,
    aprs_pfmt_cfg_if.sink   cfg
);
    import aprs_pfmt_pkg::*;

    logic [6:0] symbol_table_reg, symbol_table_next;
    logic [6:0] symbol_code_reg, symbol_code_next;
    logic [2:0] ambiguity_reg, ambiguity_next;

    logic       push_valid;
    logic       push_ready;
    pos_item_t  push_item;
    logic       pop_valid;
    logic       pop_ready;
    pos_item_t  pop_item;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        symbol_table_next = symbol_table_reg;
        symbol_code_next  = symbol_code_reg;
        ambiguity_next    = ambiguity_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SYMBOL_TABLE: symbol_table_next = cfg.data;
                CFG_SYMBOL_CODE:  symbol_code_next  = cfg.data;
                CFG_AMBIGUITY:    ambiguity_next    = cfg.data[2:0];
                default:          ambiguity_next    = ambiguity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_table_reg <= SYMBOL_TABLE_RESET[6:0];
            symbol_code_reg  <= SYMBOL_CODE_RESET[6:0];
            ambiguity_reg    <= '0;
        end
        else
        begin
            symbol_table_reg <= symbol_table_next;
            symbol_code_reg  <= symbol_code_next;
            ambiguity_reg    <= ambiguity_next;
        end
    end

    aprs_pfmt_front u_front (
        .pos        (pos),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    aprs_pfmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    aprs_pfmt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_item     (pop_item),
        .pop_ready    (pop_ready),
        .symbol_table (symbol_table_reg),
        .symbol_code  (symbol_code_reg),
        .ambiguity    (ambiguity_reg),
        .rpt          (rpt)
    );

endmodule
